### hdl/stereo_peak_rms_meter_assert.svh
// Assertion macros for the stereo peak and RMS meter.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef STEREO_PEAK_RMS_METER_ASSERT_SVH
`define STEREO_PEAK_RMS_METER_ASSERT_SVH

`ifndef SYNTH
`define SPRM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SPRM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SPRM_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SPRM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hdl/sprm_pkg.sv
package sprm_pkg;

   // Sample and accumulator widths.
   localparam int SAMPLE_W   = 16;
   localparam int MAX_BLOCK  = 4096;
   localparam int COUNT_W    = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W      = 2 * (SAMPLE_W - 1) + COUNT_W;
   localparam int ROOT_W     = SAMPLE_W;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 4;
   localparam int CALC_STEPS = SUM_W + ROOT_W;
   localparam int STEP_W     = $clog2(CALC_STEPS);
   localparam int COEFF_W    = 16;

   // Stream payload widths.
   localparam int REQ_DATA_W = 2 * SAMPLE_W;
   localparam int RSP_DATA_W = 4 * ROOT_W;

   localparam logic [COEFF_W-1:0] DECAY_RESET = 16'd65071;

   // Controller states.
   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_PEAK,
      ST_LEFT_GO,
      ST_LEFT_WAIT,
      ST_RIGHT_GO,
      ST_RIGHT_WAIT,
      ST_OUTPUT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accumulate;
      logic peak_update;
      logic calc_start;
      logic calc_right;
      logic load_out;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic block_end;
      logic calc_busy;
      logic calc_done;
      logic out_free;
   } ctrl_status_type;

endpackage

### hdl/sprm_ctrl.sv
`include "stereo_peak_rms_meter_assert.svh"

module sprm_ctrl
   import sprm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output ctrl_cmd_type    cmd,
   input  ctrl_status_type status
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (req_tvalid && status.block_end) begin
               state_in = ST_PEAK;
            end
         end
         ST_PEAK: begin
            state_in = ST_LEFT_GO;
         end
         ST_LEFT_GO: begin
            state_in = ST_LEFT_WAIT;
         end
         ST_LEFT_WAIT: begin
            if (status.calc_done) begin
               state_in = ST_RIGHT_GO;
            end
         end
         ST_RIGHT_GO: begin
            state_in = ST_RIGHT_WAIT;
         end
         ST_RIGHT_WAIT: begin
            if (status.calc_done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready      = 1'b0;
      cmd             = '0;
      case (state_ff)
         ST_ACCUM: begin
            req_tready     = 1'b1;
            cmd.accumulate = req_tvalid;
         end
         ST_PEAK: begin
            cmd.peak_update = 1'b1;
         end
         ST_LEFT_GO: begin
            cmd.calc_start = 1'b1;
         end
         ST_LEFT_WAIT: begin
            cmd.calc_right = 1'b0;
         end
         ST_RIGHT_GO: begin
            cmd.calc_start = 1'b1;
            cmd.calc_right = 1'b1;
         end
         ST_RIGHT_WAIT: begin
            cmd.calc_right = 1'b1;
         end
         ST_OUTPUT: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // The shared unit is never restarted mid-run, samples never arrive while it works,
   // and the input stalls once a pair that ends a block has been taken.
   `SPRM_ASSERT_SAME(a_start_idle, clock, reset, cmd.calc_start, !status.calc_busy)
   `SPRM_ASSERT_SAME(a_accum_idle, clock, reset, cmd.accumulate, !status.calc_busy)
   `SPRM_ASSERT_NEXT(a_end_stalls, clock, reset,
                     cmd.accumulate && status.block_end, !req_tready)

endmodule

### hdl/sprm_divsqrt.sv
module sprm_divsqrt
   import sprm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               busy,
   output logic               done,
   output logic [ROOT_W-1:0]  root
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SUM_W-1:0]   work_ff, work_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [COUNT_W-1:0] divisor_ff, divisor_in;

   logic               in_div;
   logic               last_step;
   logic [COUNT_W:0]   div_trial;
   logic [COUNT_W:0]   div_diff;
   logic               div_ge;
   logic [REM_W-1:0]   sq_rem;
   logic [REM_W-1:0]   sq_test;
   logic               sq_ge;

   // Restoring division steps first, then one root digit a cycle; the quotient
   // stays in the work register and feeds the root two bits at a time.
   always_comb begin
      in_div    = (step_ff < STEP_W'(SUM_W));
      last_step = (step_ff == STEP_W'(CALC_STEPS - 1));
      div_trial = {rem_ff[COUNT_W-1:0], work_ff[SUM_W-1]};
      div_ge    = (div_trial >= {1'b0, divisor_ff});
      div_diff  = div_trial - {1'b0, divisor_ff};
      sq_rem    = {rem_ff[REM_W-3:0], work_ff[RAD_W-1:RAD_W-2]};
      sq_test   = {{(REM_W - ROOT_W - 2){1'b0}}, root_ff, 2'b01};
      sq_ge     = (sq_rem >= sq_test);

      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      divisor_in = divisor_ff;

      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         work_in    = dividend;
         rem_in     = '0;
         root_in    = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (in_div) begin
            work_in = {work_ff[SUM_W-2:0], div_ge};
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               rem_in = '0;
            end else if (div_ge) begin
               rem_in = REM_W'(div_diff[COUNT_W-1:0]);
            end else begin
               rem_in = REM_W'(div_trial[COUNT_W-1:0]);
            end
         end else begin
            work_in = {work_ff[SUM_W-3:0], 2'b00};
            rem_in  = sq_ge ? (sq_rem - sq_test) : sq_rem;
            root_in = {root_ff[ROOT_W-2:0], sq_ge};
         end
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      divisor_ff <= divisor_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

endmodule

### hdl/sprm_datapath.sv
module sprm_datapath
   import sprm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  csr_we,
   input  logic [COEFF_W-1:0]    csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  ctrl_cmd_type          cmd,
   output ctrl_status_type       status
);

   logic [COEFF_W-1:0]    decay_ff;
   logic [SAMPLE_W-1:0]   bpeak_l_ff, bpeak_r_ff;
   logic [SUM_W-1:0]      sum_l_ff, sum_r_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [SAMPLE_W-1:0]   held_l_ff, held_r_ff;
   logic [ROOT_W-1:0]     rms_l_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic signed [SAMPLE_W-1:0] smp_l, smp_r;
   logic [SAMPLE_W-1:0]        mag_l, mag_r;
   logic [2*SAMPLE_W-1:0]      sq_l, sq_r;
   logic [SAMPLE_W+COEFF_W-1:0] dec_prod_l, dec_prod_r;
   logic [SAMPLE_W-1:0]        dec_l, dec_r;
   logic                       calc_busy, calc_done;
   logic [ROOT_W-1:0]          calc_root;
   logic                       out_free;

   // Magnitudes and squares of the incoming pair; the most negative sample
   // maps to its full magnitude.
   always_comb begin
      smp_l = signed'(req_tdata[SAMPLE_W-1:0]);
      smp_r = signed'(req_tdata[2*SAMPLE_W-1:SAMPLE_W]);
      mag_l = smp_l[SAMPLE_W-1] ? (~smp_l + 1'b1) : smp_l;
      mag_r = smp_r[SAMPLE_W-1] ? (~smp_r + 1'b1) : smp_r;
      sq_l  = mag_l * mag_l;
      sq_r  = mag_r * mag_r;
   end

   // Decayed held peaks, truncated.
   always_comb begin
      dec_prod_l = held_l_ff * decay_ff;
      dec_prod_r = held_r_ff * decay_ff;
      dec_l      = dec_prod_l[SAMPLE_W+COEFF_W-1:COEFF_W];
      dec_r      = dec_prod_r[SAMPLE_W+COEFF_W-1:COEFF_W];
   end

   // Decay coefficient register.
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DECAY_RESET;
      end else if (csr_we) begin
         decay_ff <= csr_wdata;
      end
   end

   // Block accumulators, cleared once the result has been handed on.
   always_ff @(posedge clock) begin
      if (reset || cmd.load_out) begin
         bpeak_l_ff <= '0;
         bpeak_r_ff <= '0;
         sum_l_ff   <= '0;
         sum_r_ff   <= '0;
         count_ff   <= '0;
      end else if (cmd.accumulate) begin
         if (mag_l > bpeak_l_ff) begin
            bpeak_l_ff <= mag_l;
         end
         if (mag_r > bpeak_r_ff) begin
            bpeak_r_ff <= mag_r;
         end
         sum_l_ff <= sum_l_ff + SUM_W'(sq_l);
         sum_r_ff <= sum_r_ff + SUM_W'(sq_r);
         count_ff <= count_ff + 1'b1;
      end
   end

   // Held peaks.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_l_ff <= '0;
         held_r_ff <= '0;
      end else if (cmd.peak_update) begin
         held_l_ff <= (bpeak_l_ff > dec_l) ? bpeak_l_ff : dec_l;
         held_r_ff <= (bpeak_r_ff > dec_r) ? bpeak_r_ff : dec_r;
      end
   end

   // Shared divide and root unit, left channel first.
   sprm_divsqrt u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.calc_start),
      .dividend (cmd.calc_right ? sum_r_ff : sum_l_ff),
      .divisor  (count_ff),
      .busy     (calc_busy),
      .done     (calc_done),
      .root     (calc_root)
   );

   // Left RMS is parked until the right one is ready.
   always_ff @(posedge clock) begin
      if (calc_done && !cmd.calc_right) begin
         rms_l_ff <= calc_root;
      end
   end

   // Output register.
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_data_ff <= {calc_root, rms_l_ff, held_r_ff, held_l_ff};
      end
   end

   // Status back to the controller.
   always_comb begin
      status.block_end = req_tlast || (count_ff == COUNT_W'(MAX_BLOCK - 1));
      status.calc_busy = calc_busy;
      status.calc_done = calc_done;
      status.out_free  = out_free;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

### hdl/stereo_peak_rms_meter.sv
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: left_sample, right_sample; tlast: end
// rsp       out        rsp_tvalid/rsp_tready  tdata: peak_l, peak_r, rms_l, rms_r
// csr       in         csr_we                 csr_wdata: decay coefficient
//
// A sample pair that does not end a block is taken without stalling the input.
// A pair that ends a block stalls the input for the peak update, then a shared
// 43-step divider and 16-step square root per channel, and after that until the
// previous result no longer sits unread in the output register.
// Reset clears the accumulators and held peaks and loads the decay coefficient.
// The output register lets a result wait while the next block is being accumulated.
module stereo_peak_rms_meter
   import sprm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // left_sample [15:0], right_sample [31:16]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // peak_l [15:0], peak_r [31:16], rms_l [47:32], rms_r [63:48]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [COEFF_W-1:0]    csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequencer.
   sprm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Accumulators, arithmetic and output register.
   sprm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
